// ===== design/dpts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpts_pkg
// Command, status and word types shared by the task scheduler files.
// ----------------------------------------------------------------------------
package dpts_pkg;

	typedef enum logic [1:0] {
		CMD_INIT     = 2'd0,
		CMD_ADD_DEP  = 2'd1,
		CMD_SUBMIT   = 2'd2,
		CMD_DISPATCH = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_FULL   = 3'd2,
		ST_HELD   = 3'd3,
		ST_QUEUED = 3'd4
	} status_t;

	localparam int PEND_W = 8;
	localparam logic [PEND_W-1:0] PENDING_MAX = 8'd255;

	typedef struct packed {
		logic [1:0]         command;
		logic [3:0]         node_index;
		logic [3:0]         child_index;
		logic [31:0]        context_tag;
		logic signed [7:0]  priority_req;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        dispatched;
		logic [3:0]  out_node;
		logic [31:0] out_context;
	} result_t;

endpackage

// ===== design/dependency_priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_priority_task_scheduler
// Task table with dependency counts, child lists and a priority ready queue.
// ----------------------------------------------------------------------------
// Submit walks the ready queue from its tail; dispatch pops the head, then visits every
// child of that node and inserts each child made ready into the queue.
// One command at a time; busy stays high until the result strobe, all steps
// run through the dual-port table RAMs under one sequencer.
// Result holds on done for one cycle; the receiver cannot stall.
// Reset (arst_n low) empties the queue and marks every table entry as zero.
module dependency_priority_task_scheduler #(
	parameter int NODES         = 16,
	parameter int MAX_CHILDREN  = 4,
	parameter int PRIORITY_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dpts_pkg::request_t request,
	output logic              busy,
	output logic              done,
	output dpts_pkg::result_t result
);

	localparam int NW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam int KW = $clog2(MAX_CHILDREN + 1);
	localparam int SD = NODES * MAX_CHILDREN;
	localparam int SW = $clog2(SD);
	localparam int PW = PRIORITY_BITS;
	localparam int NDW = 32 + PW;
	localparam longint PMAX = (longint'(1) << (PW - 1)) - 1;
	localparam longint PMIN = -PMAX - 1;
	localparam int PEND_W_L = dpts_pkg::PEND_W;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_ADD_RD, S_ADD_WR, S_SUB_RD, S_SUB_CHK,
		S_INS_P, S_INS_PW, S_INS_CHK, S_INS_RO, S_INS_CMP, S_INS_PUT,
		S_DSP_RD, S_DSP_H, S_DSP_C, S_REL_CHK, S_REL_S, S_REL_P
	} state_t;

	state_t state_q;

	logic [1:0]         cmd_q;
	logic [NW-1:0]      n_q, c_q, x_q, t_q, h_q;
	logic [31:0]        ctx_q;
	logic signed [PW-1:0] prio_q, px_q;
	logic [LW-1:0]      len_q, ik_q;
	logic [NW-1:0]      head_q;
	logic [KW-1:0]      rk_q;
	logic               ret_rel_q;
	logic [NODES-1:0]   in_ready_q, nval_q, pvld_q, cvld_q;
	logic               done_q;
	dpts_pkg::result_t  res_q;

	function automatic logic signed [PW-1:0] clamp(input logic signed [7:0] p);
		longint v;
		v = longint'(p);
		if (v > PMAX) v = PMAX;
		if (v < PMIN) v = PMIN;
		return PW'(v);
	endfunction

	function automatic logic [NW-1:0] ring(input logic [NW-1:0] base,
			input logic [LW-1:0] off);
		int s;
		s = int'(base) + int'(off);
		if (s >= NODES) s = s - NODES;
		return NW'(s);
	endfunction

	// small lookup: 4-bit index folded into the table range
	function automatic logic [NW-1:0] wrap_node(input logic [3:0] v);
		logic [NW-1:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (v == 4'(i)) r = NW'(i % NODES);
		end
		return r;
	endfunction

	// table RAMs
	logic            nd_we;
	logic [NW-1:0]   nd_raddr;
	logic [NDW-1:0]  nd_rdata;
	logic            pd_we;
	logic [NW-1:0]   pd_waddr, pd_raddr;
	logic [PEND_W_L-1:0] pd_wdata, pd_rdata;
	logic            cc_we;
	logic [NW-1:0]   cc_raddr;
	logic [KW-1:0]   cc_wdata, cc_rdata;
	logic            sl_we;
	logic [SW-1:0]   sl_waddr, sl_raddr;
	logic [NW-1:0]   sl_rdata;
	logic            ro_we;
	logic [NW-1:0]   ro_waddr, ro_raddr, ro_wdata, ro_rdata;

	logic signed [PW-1:0] rd_prio, pt;
	logic [KW-1:0]   cc_cur;
	logic [PEND_W_L-1:0] pv;
	logic            cc_ok;

	assign rd_prio = nd_rdata[PW-1:0];
	assign pt = nval_q[t_q] ? rd_prio : '0;
	assign cc_cur = cvld_q[n_q] ? cc_rdata : '0;
	assign cc_ok = int'(cc_cur) < MAX_CHILDREN;
	assign pv = pvld_q[c_q] ? pd_rdata : '0;

	always_comb begin
		nd_we    = (state_q == S_INIT) && !in_ready_q[n_q];
		nd_raddr = x_q;
		if (state_q == S_INS_RO || state_q == S_DSP_H) begin
			nd_raddr = ro_rdata;
		end
		pd_raddr = n_q;
		if (state_q == S_ADD_RD) pd_raddr = c_q;
		if (state_q == S_REL_S)  pd_raddr = sl_rdata;
		pd_we    = 1'b0;
		pd_waddr = c_q;
		pd_wdata = pv - 1'b1;
		if (state_q == S_ADD_WR && cc_ok) begin
			pd_we    = 1'b1;
			pd_wdata = (pv == dpts_pkg::PENDING_MAX) ? pv : pv + 1'b1;
		end
		if (state_q == S_REL_P && pv != '0) begin
			pd_we = 1'b1;
		end
		cc_raddr = (state_q == S_DSP_H) ? ro_rdata : n_q;
		cc_we    = (state_q == S_ADD_WR) && cc_ok;
		cc_wdata = cc_cur + 1'b1;
		sl_we    = (state_q == S_ADD_WR) && cc_ok;
		sl_waddr = SW'(int'(n_q) * MAX_CHILDREN + int'(cc_cur));
		sl_raddr = SW'(int'(h_q) * MAX_CHILDREN + int'(rk_q) - 1);
		ro_raddr = (state_q == S_DSP_RD) ? head_q : ring(head_q, ik_q - 1'b1);
		ro_waddr = ring(head_q, ik_q);
		ro_we    = 1'b0;
		ro_wdata = x_q;
		if (state_q == S_INS_CMP && pt < px_q) begin
			ro_we    = 1'b1;
			ro_wdata = t_q;
		end
		if (state_q == S_INS_PUT) ro_we = 1'b1;
	end

	dpts_ram #(.DEPTH(NODES), .WIDTH(NDW)) u_node (
		.clk(clk), .we(nd_we), .waddr(n_q), .wdata({ctx_q, prio_q}),
		.raddr(nd_raddr), .rdata(nd_rdata)
	);
	dpts_ram #(.DEPTH(NODES), .WIDTH(PEND_W_L)) u_pend (
		.clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
		.raddr(pd_raddr), .rdata(pd_rdata)
	);
	dpts_ram #(.DEPTH(NODES), .WIDTH(KW)) u_ccnt (
		.clk(clk), .we(cc_we), .waddr(n_q), .wdata(cc_wdata),
		.raddr(cc_raddr), .rdata(cc_rdata)
	);
	dpts_ram #(.DEPTH(SD), .WIDTH(NW)) u_slot (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(c_q),
		.raddr(sl_raddr), .rdata(sl_rdata)
	);
	dpts_ram #(.DEPTH(NODES), .WIDTH(NW)) u_ready (
		.clk(clk), .we(ro_we), .waddr(ro_waddr), .wdata(ro_wdata),
		.raddr(ro_raddr), .rdata(ro_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			n_q        <= '0;
			c_q        <= '0;
			x_q        <= '0;
			t_q        <= '0;
			h_q        <= '0;
			ctx_q      <= '0;
			prio_q     <= '0;
			px_q       <= '0;
			len_q      <= '0;
			ik_q       <= '0;
			head_q     <= '0;
			rk_q       <= '0;
			ret_rel_q  <= 1'b0;
			in_ready_q <= '0;
			nval_q     <= '0;
			pvld_q     <= '0;
			cvld_q     <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= request.command;
						n_q       <= wrap_node(request.node_index);
						c_q       <= wrap_node(request.child_index);
						ctx_q     <= request.context_tag;
						prio_q    <= clamp(request.priority_req);
						res_q     <= '0;
						ret_rel_q <= 1'b0;
						unique case (dpts_pkg::cmd_t'(request.command))
							dpts_pkg::CMD_INIT:     state_q <= S_INIT;
							dpts_pkg::CMD_ADD_DEP:  state_q <= S_ADD_RD;
							dpts_pkg::CMD_SUBMIT:   state_q <= S_SUB_RD;
							dpts_pkg::CMD_DISPATCH: state_q <= S_DSP_RD;
						endcase
					end
				end
				S_INIT: begin
					if (in_ready_q[n_q]) begin
						res_q.status <= dpts_pkg::ST_QUEUED;
					end else begin
						nval_q[n_q] <= 1'b1;
						pvld_q[n_q] <= 1'b0;
						cvld_q[n_q] <= 1'b0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					if (cc_ok) begin
						cvld_q[n_q] <= 1'b1;
						pvld_q[c_q] <= 1'b1;
					end else begin
						res_q.status <= dpts_pkg::ST_FULL;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SUB_RD: begin
					c_q <= n_q;
					if (in_ready_q[n_q]) begin
						res_q.status <= dpts_pkg::ST_QUEUED;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SUB_CHK;
					end
				end
				S_SUB_CHK: begin
					if (pv != '0) begin
						res_q.status <= dpts_pkg::ST_HELD;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						x_q     <= n_q;
						state_q <= S_INS_P;
					end
				end
				S_INS_P: begin
					if (in_ready_q[x_q] || int'(len_q) >= NODES) begin
						if (ret_rel_q) begin
							state_q <= S_REL_CHK;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_INS_PW;
					end
				end
				S_INS_PW: begin
					px_q    <= nval_q[x_q] ? rd_prio : '0;
					ik_q    <= len_q;
					state_q <= S_INS_CHK;
				end
				// walk from the tail, shifting lower-priority entries back
				S_INS_CHK: state_q <= (ik_q == '0) ? S_INS_PUT : S_INS_RO;
				S_INS_RO: begin
					t_q     <= ro_rdata;
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (pt < px_q) begin
						ik_q    <= ik_q - 1'b1;
						state_q <= S_INS_CHK;
					end else begin
						state_q <= S_INS_PUT;
					end
				end
				S_INS_PUT: begin
					len_q           <= len_q + 1'b1;
					in_ready_q[x_q] <= 1'b1;
					if (ret_rel_q) begin
						state_q <= S_REL_CHK;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DSP_RD: begin
					if (len_q == '0) begin
						res_q.status <= dpts_pkg::ST_EMPTY;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_DSP_H;
					end
				end
				S_DSP_H: begin
					h_q                  <= ro_rdata;
					head_q               <= ring(head_q, LW'(1));
					len_q                <= len_q - 1'b1;
					in_ready_q[ro_rdata] <= 1'b0;
					state_q              <= S_DSP_C;
				end
				S_DSP_C: begin
					res_q.dispatched  <= 1'b1;
					res_q.out_node    <= 4'(h_q);
					res_q.out_context <= nval_q[h_q] ? nd_rdata[NDW-1:PW] : 32'd0;
					rk_q              <= cvld_q[h_q] ? cc_rdata : '0;
					cvld_q[h_q]       <= 1'b0;
					ret_rel_q         <= 1'b1;
					state_q           <= S_REL_CHK;
				end
				// children newest first
				S_REL_CHK: begin
					if (rk_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						rk_q    <= rk_q - 1'b1;
						state_q <= S_REL_S;
					end
				end
				S_REL_S: begin
					c_q     <= sl_rdata;
					state_q <= S_REL_P;
				end
				S_REL_P: begin
					state_q <= S_REL_CHK;
					if (pv != '0) begin
						pvld_q[c_q] <= 1'b1;
						if (pv == PEND_W_L'(1)) begin
							x_q     <= c_q;
							state_q <= S_INS_P;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(len_q) <= NODES) else $error("ready queue length overflow");
	a_strobe_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held over two cycles");
	a_disp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.dispatched |-> result.status == dpts_pkg::ST_OK)
		else $error("dispatch with error status");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy) |-> $stable(cmd_q)) else $error("command lost mid-run");
`endif

endmodule

// ===== design/dpts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpts_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/sv/tb_dependency_priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dependency_priority_task_scheduler
// Drives random and directed scheduler commands, predicts each result word
// with a behavioral task table and ready queue, and compares every strobe.
// ----------------------------------------------------------------------------
module tb_dependency_priority_task_scheduler;

	localparam int NN = 16;
	localparam int MAXC = 4;

	logic clk;
	logic arst_n;
	logic start;
	dpts_pkg::request_t request;
	logic busy;
	logic done;
	dpts_pkg::result_t result;

	dependency_priority_task_scheduler u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .done(done), .result(result)
	);

	// scheduler image
	logic signed [7:0] prio_tbl [NN];
	logic [31:0] ctx_tbl [NN];
	logic [7:0] pend_tbl [NN];
	logic [3:0] kids [NN][MAXC];
	int kid_cnt [NN];
	logic [3:0] rdy_q [$];
	bit queued [NN];

	dpts_pkg::request_t pending_words [$];
	dpts_pkg::result_t expected_results [$];
	int sender_idle_pct;
	bit failed;
	bit stim_done;

	task automatic ready_insert(input logic [3:0] n);
		int pos;
		if (queued[n] || rdy_q.size() >= NN) return;
		pos = 0;
		while (pos < rdy_q.size() && prio_tbl[rdy_q[pos]] >= prio_tbl[n]) pos++;
		rdy_q.insert(pos, n);
		queued[n] = 1;
	endtask

	task automatic schedule_word(input dpts_pkg::request_t r);
		dpts_pkg::result_t res;
		logic [3:0] n, c, h, k;
		res = '0;
		n = r.node_index;
		c = r.child_index;
		case (dpts_pkg::cmd_t'(r.command))
			dpts_pkg::CMD_INIT: begin
				if (queued[n]) res.status = dpts_pkg::ST_QUEUED;
				else begin
					ctx_tbl[n] = r.context_tag;
					prio_tbl[n] = r.priority_req;
					pend_tbl[n] = '0;
					kid_cnt[n] = 0;
				end
			end
			dpts_pkg::CMD_ADD_DEP: begin
				if (kid_cnt[n] >= MAXC) res.status = dpts_pkg::ST_FULL;
				else begin
					kids[n][kid_cnt[n]] = c;
					kid_cnt[n]++;
					if (pend_tbl[c] < dpts_pkg::PENDING_MAX) pend_tbl[c]++;
				end
			end
			dpts_pkg::CMD_SUBMIT: begin
				if (queued[n]) res.status = dpts_pkg::ST_QUEUED;
				else if (pend_tbl[n] != 0) res.status = dpts_pkg::ST_HELD;
				else ready_insert(n);
			end
			default: begin
				if (rdy_q.size() == 0) res.status = dpts_pkg::ST_EMPTY;
				else begin
					h = rdy_q.pop_front();
					queued[h] = 0;
					res.dispatched = 1;
					res.out_node = h;
					res.out_context = ctx_tbl[h];
					// newest child first
					for (int i = kid_cnt[h] - 1; i >= 0; i--) begin
						k = kids[h][i];
						if (pend_tbl[k] > 0) begin
							pend_tbl[k]--;
							if (pend_tbl[k] == 0) ready_insert(k);
						end
					end
					kid_cnt[h] = 0;
				end
			end
		endcase
		expected_results.push_back(res);
	endtask

	function automatic dpts_pkg::request_t mk(input dpts_pkg::cmd_t cm, input int n,
			input int c, input int unsigned ctx, input int p);
		dpts_pkg::request_t r;
		r.command = cm;
		r.node_index = 4'(n);
		r.child_index = 4'(c);
		r.context_tag = ctx;
		r.priority_req = 8'(p);
		return r;
	endfunction

	function automatic dpts_pkg::request_t rnd_word();
		int sel;
		dpts_pkg::cmd_t cm;
		sel = $urandom_range(0, 99);
		// favor small node sets so chains form; keep dispatch frequent
		if (sel < 20) cm = dpts_pkg::CMD_INIT;
		else if (sel < 45) cm = dpts_pkg::CMD_ADD_DEP;
		else if (sel < 72) cm = dpts_pkg::CMD_SUBMIT;
		else cm = dpts_pkg::CMD_DISPATCH;
		return mk(cm, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5),
			$urandom_range(0, 15) < 12 ? $urandom_range(0, 5) : $urandom_range(0, 15),
			$urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 3));
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		for (int i = 0; i < NN; i++) begin
			prio_tbl[i] = '0; ctx_tbl[i] = '0; pend_tbl[i] = '0; kid_cnt[i] = 0; queued[i] = 0;
		end
		failed = 0;
		stim_done = 0;
		sender_idle_pct = 38;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed part
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_INIT, 0, 15, 32'hFFFF_FFFF, 127));
		pending_words.push_back(mk(dpts_pkg::CMD_INIT, 15, 0, 0, 128));
		pending_words.push_back(mk(dpts_pkg::CMD_INIT, 1, 0, 32'hA5A5_5A5A, 127));
		pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 0, 15, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 0, 15, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 0, 2, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 0, 3, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 0, 4, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_SUBMIT, 15, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_SUBMIT, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_SUBMIT, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_INIT, 0, 0, 1, 1));
		pending_words.push_back(mk(dpts_pkg::CMD_SUBMIT, 1, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_SUBMIT, 5, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		// child made ready when its only parent is dispatched
		pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 6, 7, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_SUBMIT, 6, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		pending_words.push_back(mk(dpts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
		// saturate a pending count: re-init one parent to reuse its four child slots
		for (int rd = 0; rd < 64; rd++) begin
			pending_words.push_back(mk(dpts_pkg::CMD_INIT, 10, 0, rd, 0));
			for (int j = 0; j < 4; j++)
				pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 10, 9, 0, 0));
		end
		pending_words.push_back(mk(dpts_pkg::CMD_ADD_DEP, 10, 9, 0, 0));
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 46 : 0;
			for (int i = 0; i < 120; i++) pending_words.push_back(rnd_word());
			wait (pending_words.size() == 0);
		end
		stim_done = 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			request <= '0;
		end else if (start && !busy) begin
			// word accepted at this edge
			schedule_word(request);
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				request <= pending_words.pop_front();
			end else begin
				start <= 0;
			end
		end else if (!start && pending_words.size() != 0 &&
				$urandom_range(0, 99) >= sender_idle_pct) begin
			start <= 1;
			request <= pending_words.pop_front();
		end
	end

	// monitor
	always @(posedge clk) begin
		dpts_pkg::result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				failed = 1;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.status !== exp_r.status)
					$display("%0t: status exp %0d got %0d", $time, exp_r.status, result.status);
				if (result.dispatched !== exp_r.dispatched)
					$display("%0t: dispatched exp %0d got %0d", $time, exp_r.dispatched,
						result.dispatched);
				if (result.out_node !== exp_r.out_node)
					$display("%0t: out_node exp %0d got %0d", $time, exp_r.out_node,
						result.out_node);
				if (result.out_context !== exp_r.out_context)
					$display("%0t: out_context exp %h got %h", $time, exp_r.out_context,
						result.out_context);
				if (result !== exp_r) failed = 1;
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (start == 0 && expected_results.size() == 0);
		repeat (300) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
